### hdl/psrf_pkg.sv
// Shared types and constants for the PPM sum receiver and channel filter.
`default_nettype none

package psrf_pkg;

  // Block dimensions.
  localparam int NumChannels      = 12;
  localparam int AvgLength        = 4;
  localparam int OverrideChannels = 8;
  localparam int HistLen          = AvgLength - 1;
  localparam int OrderSlots       = 12;

  localparam int ChW    = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int HiW    = (HistLen > 1) ? $clog2(HistLen) : 1;
  localparam int OvW    = (OverrideChannels > 1) ? $clog2(OverrideChannels) : 1;
  localparam int RawW   = 12;
  localparam int SumW   = RawW + $clog2(AvgLength) + 1;
  localparam int RowW   = HistLen * RawW;
  localparam int SlotW  = 4;

  // Queue sizes.
  localparam int CmdDepth = 4;
  localparam int CmdPtrW  = 2;
  localparam int OutDepth = 16;
  localparam int OutPtrW  = 4;

  // Values of the decoder and filter.
  localparam logic [RawW-1:0]  IdleRaw       = RawW'(1502);
  localparam logic [15:0]      IdleFilt      = 16'd1500;
  localparam logic [RawW-1:0]  RawMax        = RawW'(4095);
  localparam logic [SlotW-1:0] SlotMax       = 4'd15;
  localparam logic [15:0]      OverrideFloor = 16'd900;
  localparam int               Deadband      = 3;
  localparam int               Settle        = 2;

  // Configuration register reset values.
  localparam logic [47:0] OrderReset    = 48'hBA98_7654_3210;
  localparam logic [15:0] SyncGapReset  = 16'd3000;
  localparam logic [15:0] PulseMinReset = 16'd900;
  localparam logic [15:0] PulseMaxReset = 16'd2200;

  typedef enum logic [1:0] {
    KIND_EDGE      = 2'd0,
    KIND_PASS      = 2'd1,
    KIND_OVR_LOAD  = 2'd2,
    KIND_OVR_COUNT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_ORDER     = 2'd0,
    CFG_SYNC_GAP  = 2'd1,
    CFG_PULSE_MIN = 2'd2,
    CFG_PULSE_MAX = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_RAW  = 2'd0,
    CMD_PASS = 2'd1,
    CMD_OVR  = 2'd2,
    CMD_CNT  = 2'd3
  } cmd_op_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] timestamp;
    logic [2:0]  channel;
    logic [15:0] value;
    logic [15:0] count;
  } in_t;

  typedef struct packed {
    logic [3:0]  out_channel;
    logic [15:0] out_value;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [47:0] order;
    logic [15:0] sync_gap;
    logic [15:0] pulse_min;
    logic [15:0] pulse_max;
  } cfg_t;

  // Command from the front end to the back end.
  typedef struct packed {
    cmd_op_e        op;
    logic [SlotW-1:0] idx;
    logic [15:0]    data;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/psrf_fifo.sv
// Small command queue between the front end and the back end.
`default_nettype none

module psrf_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  psrf_pkg::cmd_t   data_i,
  output logic             full_o,
  input  logic             pop_i,
  output psrf_pkg::cmd_t   data_o,
  output logic             empty_o
);
  import psrf_pkg::*;

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_q, rd_q;
  logic [CmdPtrW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (int'(cnt_q) == CmdDepth);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/psrf_front.sv
// Front end: accepts requests, decodes PPM pulse timestamps and issues commands.
`default_nettype none

module psrf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psrf_pkg::cfg_t cfg_i,
  input  logic           push,
  output logic           full,
  input  psrf_pkg::in_t  item_i,
  output logic           cmd_push_o,
  output psrf_pkg::cmd_t cmd_o,
  input  logic           cmd_full_i
);
  import psrf_pkg::*;

  logic [15:0]      last_q, last_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [15:0]      diff;
  logic             accept;
  logic             in_window;

  assign full      = cmd_full_i;
  assign accept    = push && !cmd_full_i;
  assign diff      = item_i.timestamp - last_q;
  assign in_window = (diff > cfg_i.pulse_min) && (diff < cfg_i.pulse_max)
                     && (int'(slot_q) < NumChannels);

  // Request decode and frame tracking.
  always_comb begin
    last_d     = last_q;
    slot_d     = slot_q;
    cmd_push_o = 1'b0;
    cmd_o.op   = CMD_RAW;
    cmd_o.idx  = slot_q;
    cmd_o.data = '0;
    unique case (item_i.kind)
      KIND_EDGE: begin
        if (accept) begin
          last_d = item_i.timestamp;
          if (diff > cfg_i.sync_gap) begin
            slot_d = '0;
          end else begin
            if (in_window) begin
              cmd_push_o = 1'b1;
              cmd_o.data = (diff > 16'(RawMax)) ? 16'(RawMax) : diff;
            end
            if (slot_q < SlotMax) begin
              slot_d = slot_q + 1'b1;
            end
          end
        end
      end
      KIND_PASS: begin
        cmd_o.op   = CMD_PASS;
        cmd_push_o = accept;
      end
      KIND_OVR_LOAD: begin
        cmd_o.op   = CMD_OVR;
        cmd_o.idx  = SlotW'(item_i.channel);
        cmd_o.data = item_i.value;
        cmd_push_o = accept && (int'(item_i.channel) < OverrideChannels);
      end
      KIND_OVR_COUNT: begin
        cmd_o.op   = CMD_CNT;
        cmd_o.data = item_i.count;
        cmd_push_o = accept;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      slot_q <= '0;
    end else begin
      last_q <= last_d;
      slot_q <= slot_d;
    end
  end

endmodule

`default_nettype wire

### hdl/psrf_back.sv
// Back end: channel filter pipeline, override logic and result queue.
`default_nettype none

module psrf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [47:0]    order_i,
  input  psrf_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output psrf_pkg::out_t result_o,
  output logic           empty,
  input  logic           pop
);
  import psrf_pkg::*;

  // Channel state.
  logic [RawW-1:0] raw_q  [NumChannels];
  logic [15:0]     filt_q [NumChannels];
  logic [15:0]     ov_q   [OverrideChannels];
  logic [15:0]     ocnt_q;
  logic [HiW-1:0]  hidx_q;

  // History memory, one row of past raw values per channel.
  logic [RowW-1:0]        hist_mem [NumChannels];
  logic [RowW-1:0]        hist_rd_q;
  logic [NumChannels-1:0] hvld_q;

  // Pass sequencer and pipeline.
  logic            active_q;
  logic [ChW-1:0]  ch_q;
  logic            s1_vld_q, s1_hok_q;
  logic [ChW-1:0]  s1_ch_q;
  logic [RawW-1:0] s1_raw_q;
  logic            s2_vld_q;
  logic [ChW-1:0]  s2_ch_q;
  logic [RawW-1:0] s2_raw_q, s2_mean_q;
  logic [RowW-1:0] s2_row_q;

  // Result queue.
  out_t               oq_mem [OutDepth];
  logic [OutPtrW-1:0] oq_wr_q, oq_rd_q;
  logic [OutPtrW:0]   oq_cnt_q;

  logic            busy, room, start, oq_pop;
  logic [SlotW-1:0] slot;
  logic [RawW-1:0] raw_sel;
  logic [SumW-1:0] sum;
  logic [RowW-1:0] row_m, row_new;
  logic [RawW-1:0] mean;
  logic [15:0]     f_cur, f_new, ov_cur;
  logic            ovr_hit;
  out_t            res;

  assign busy      = active_q || s1_vld_q || s2_vld_q;
  assign room      = (int'(oq_cnt_q) <= OutDepth - NumChannels);
  assign cmd_pop_o = !cmd_empty_i && !busy && ((cmd_i.op != CMD_PASS) || room);
  assign start     = cmd_pop_o && (cmd_i.op == CMD_PASS);

  // Stage 0: slot lookup through the channel order.
  always_comb begin
    if (int'(ch_q) < OrderSlots) begin
      slot = order_i[{ch_q, 2'b00} +: SlotW];
    end else begin
      slot = SlotW'(ch_q);
    end
    if (int'(slot) < NumChannels) begin
      raw_sel = raw_q[ChW'(slot)];
    end else begin
      raw_sel = IdleRaw;
    end
  end

  // Stage 1: rounded mean over the raw value and the history row.
  always_comb begin
    row_m = s1_hok_q ? hist_rd_q : '0;
    sum   = SumW'(s1_raw_q) + SumW'(AvgLength / 2);
    for (int a = 0; a < HistLen; a++) begin
      sum = sum + SumW'(row_m[a*RawW +: RawW]);
    end
    mean = RawW'(sum / AvgLength);
  end

  // Stage 2: deadband, override and history update.
  always_comb begin
    f_cur   = filt_q[s2_ch_q];
    ov_cur  = ov_q[OvW'(s2_ch_q)];
    ovr_hit = (int'(s2_ch_q) < OverrideChannels) && (ocnt_q != '0);
    f_new   = f_cur;
    if ((18'(s2_mean_q) + 18'(Deadband)) < 18'(f_cur)) begin
      f_new = 16'(s2_mean_q) + 16'(Settle);
    end else if (18'(s2_mean_q) > (18'(f_cur) + 18'(Deadband))) begin
      f_new = 16'(s2_mean_q) - 16'(Settle);
    end
    if (ovr_hit && (ov_cur > OverrideFloor)) begin
      f_new = ov_cur;
    end
    for (int a = 0; a < HistLen; a++) begin
      if (int'(hidx_q) == a) begin
        row_new[a*RawW +: RawW] = s2_raw_q;
      end else begin
        row_new[a*RawW +: RawW] = s2_row_q[a*RawW +: RawW];
      end
    end
    res.out_channel = 4'(s2_ch_q);
    res.out_value   = f_new;
    res.last        = (int'(s2_ch_q) == NumChannels - 1);
  end

  // History memory access.
  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      hist_mem[s2_ch_q] <= row_new;
    end
    hist_rd_q <= hist_mem[ch_q];
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    s1_ch_q   <= ch_q;
    s1_raw_q  <= raw_sel;
    s1_hok_q  <= hvld_q[ch_q];
    s2_ch_q   <= s1_ch_q;
    s2_raw_q  <= s1_raw_q;
    s2_mean_q <= mean;
    s2_row_q  <= row_m;
  end

  // Sequencer, channel state and commands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ch_q     <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      hidx_q   <= '0;
      ocnt_q   <= '0;
      hvld_q   <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        raw_q[i]  <= IdleRaw;
        filt_q[i] <= IdleFilt;
      end
      for (int i = 0; i < OverrideChannels; i++) begin
        ov_q[i] <= '0;
      end
    end else begin
      s1_vld_q <= active_q;
      s2_vld_q <= s1_vld_q;
      if (start) begin
        active_q <= 1'b1;
        ch_q     <= '0;
        if (int'(hidx_q) == HistLen - 1) begin
          hidx_q <= '0;
        end else begin
          hidx_q <= hidx_q + 1'b1;
        end
      end else if (active_q) begin
        if (int'(ch_q) == NumChannels - 1) begin
          active_q <= 1'b0;
        end else begin
          ch_q <= ch_q + 1'b1;
        end
      end
      if (cmd_pop_o) begin
        unique case (cmd_i.op)
          CMD_RAW:  raw_q[ChW'(cmd_i.idx)] <= cmd_i.data[RawW-1:0];
          CMD_OVR:  ov_q[OvW'(cmd_i.idx)]  <= cmd_i.data;
          CMD_CNT:  ocnt_q                 <= cmd_i.data;
          CMD_PASS: ;
        endcase
      end
      if (s2_vld_q) begin
        filt_q[s2_ch_q] <= f_new;
        hvld_q[s2_ch_q] <= 1'b1;
        if (ovr_hit) begin
          ocnt_q <= ocnt_q - 1'b1;
        end
      end
    end
  end

  // Result queue.
  assign empty    = (oq_cnt_q == '0);
  assign oq_pop   = pop && !empty;
  assign result_o = oq_mem[oq_rd_q];

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      oq_mem[oq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (s2_vld_q) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
      if (s2_vld_q && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + 1'b1;
      end else if (!s2_vld_q && oq_pop) begin
        oq_cnt_q <= oq_cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ppm_sum_receiver_filter.sv
// A request is taken whenever the 4-entry command queue has room, and it leaves that
// queue in the cycle after it was written at the earliest. An edge, override or count
// request takes effect at the edge that removes it. A compute pass holds the 3-stage
// channel pipeline: its 12 results enter the 16-entry result queue on consecutive
// cycles, each after passing stages 0, 1 and 2 in order. A pass starts only when
// the result queue can hold all of it. Reset is asynchronous and active low; state
// registers reset at once, but queue storage, history memory and pipeline payload do not.
`default_nettype none

module ppm_sum_receiver_filter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  psrf_pkg::in_t  item_i,
  output logic           empty,
  input  logic           pop,
  output psrf_pkg::out_t result_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [47:0]    cfg_data_i
);
  import psrf_pkg::*;

  cfg_t cfg_q;
  cmd_t f_cmd, b_cmd;
  logic f_push, q_full, q_empty, b_pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.order     <= OrderReset;
      cfg_q.sync_gap  <= SyncGapReset;
      cfg_q.pulse_min <= PulseMinReset;
      cfg_q.pulse_max <= PulseMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_ORDER:     cfg_q.order     <= cfg_data_i;
        CFG_SYNC_GAP:  cfg_q.sync_gap  <= cfg_data_i[15:0];
        CFG_PULSE_MIN: cfg_q.pulse_min <= cfg_data_i[15:0];
        CFG_PULSE_MAX: cfg_q.pulse_max <= cfg_data_i[15:0];
      endcase
    end
  end

  psrf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .cmd_push_o (f_push),
    .cmd_o      (f_cmd),
    .cmd_full_i (q_full)
  );

  psrf_fifo u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_cmd),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .data_o  (b_cmd),
    .empty_o (q_empty)
  );

  psrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .order_i     (cfg_q.order),
    .cmd_i       (b_cmd),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (b_pop),
    .result_o    (result_o),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

`default_nettype wire
